// ----- hdl/modbus_rtu_register_slave_macros.svh -----
// Assertion macros for the Modbus RTU register slave.
// Used by files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef MODBUS_RTU_REGISTER_SLAVE_MACROS_SVH
`define MODBUS_RTU_REGISTER_SLAVE_MACROS_SVH

// same-cycle implication
`define MRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mrs_pkg.sv -----
// Shared types, codes and the CRC-16 step for the Modbus RTU register slave.
// No dependencies.
package mrs_pkg;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] FC_READ   = 8'h03;
  localparam logic [7:0] FC_WRITE1 = 8'h06;
  localparam logic [7:0] FC_WRITEN = 8'h10;

  localparam logic [7:0] EXC_FUNC  = 8'h01;
  localparam logic [7:0] EXC_RANGE = 8'h02;
  localparam logic [7:0] EXC_COUNT = 8'h03;
  localparam logic [7:0] EXC_FLAG  = 8'h80;

  localparam logic       OUT_FRAME = 1'b0;
  localparam logic       OUT_LOCAL = 1'b1;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int HDR_BYTES = 7;

  typedef enum logic [1:0] {
    RESP_EXC,
    RESP_READ,
    RESP_ECHO
  } resp_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic [7:0]  local_index;
    logic [15:0] local_value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/modbus_rtu_register_slave.sv -----
// Top level of the Modbus RTU register slave: config registers, front queue, engine.
// Depends on mrs_pkg, mrs_front, mrs_engine and modbus_rtu_register_slave_macros.svh.
//
// Input stream: tuser selects the request (frame byte, local write, local read),
// tlast marks the last byte of a frame. Output stream: tuser 0 is a response
// byte with tlast on the final byte, tuser 1 is local read data (tlast set).
// A two-entry queue sits between input and engine, so requests are taken while
// a result waits at the output register.
// Timing: the engine takes frame bytes and local writes in ST_IDLE while the
// output register is free; a local read loads its result there. At frame end
// ST_CHECK runs, then the response streams at one byte per cycle unless the
// receiver stalls. Function 16 first steps ST_RDHI, ST_RDLO and ST_WRITE per
// register written, set by the single registered read port of the frame buffer.
// Local read data is valid in the cycle after its request is taken.
// Reset clears the holding registers, frame state and queue; slave address
// returns to 1 and the protected index to 255. A stalled receiver holds the
// output register, then the engine, then the queue, then s_axis_tready.
module modbus_rtu_register_slave import mrs_pkg::*; #(
  parameter int NUM_REGS    = 16,
  parameter int FRAME_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // rx_byte[7:0], local_index[15:8], local_value[31:16]
  input  logic        s_axis_tlast,
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // tx_byte[7:0], read_value[23:8]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // out_kind[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  slave_addr_q, prot_idx_q;
  logic        cfg_we;
  item_t       in_item;
  queue_t      head;
  logic        pop;
  logic        okind, olast;
  logic [7:0]  obyte;
  logic [15:0] oval;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {24'h0, prot_idx_q} : {24'h0, slave_addr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'd1;
      prot_idx_q   <= 8'd255;
    end else if (cfg_we) begin
      if (paddr[2]) prot_idx_q   <= pwdata[7:0];
      else          slave_addr_q <= pwdata[7:0];
    end
  end

  assign in_item.kind        = s_axis_tuser;
  assign in_item.rx_byte     = s_axis_tdata[7:0];
  assign in_item.frame_end   = s_axis_tlast;
  assign in_item.local_index = s_axis_tdata[15:8];
  assign in_item.local_value = s_axis_tdata[31:16];

  mrs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .head_o     (head),
    .pop_i      (pop)
  );

  mrs_engine #(
    .NUM_REGS    (NUM_REGS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slave_addr_i (slave_addr_q),
    .prot_idx_i   (prot_idx_q),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (okind),
    .out_byte_o   (obyte),
    .out_last_o   (olast),
    .out_value_o  (oval)
  );

  assign m_axis_tdata = {oval, obyte};
  assign m_axis_tlast = olast;
  assign m_axis_tuser = okind;

`include "modbus_rtu_register_slave_macros.svh"

  `MRS_ASSERT_IMP(a_local_last, m_axis_tvalid && (m_axis_tuser == OUT_LOCAL), m_axis_tlast, "local result without tlast")
  `MRS_ASSERT_IMP(a_local_byte, m_axis_tvalid && (m_axis_tuser == OUT_LOCAL), m_axis_tdata[7:0] == 8'h00, "local result with nonzero byte")
  `MRS_ASSERT_IMP(a_full_head, !s_axis_tready, head.valid, "input stalled with empty queue")
  `MRS_ASSERT_NXT(a_cfg_addr, cfg_we && !paddr[2], slave_addr_q == $past(pwdata[7:0]), "slave address not written")

endmodule

// ----- hdl/mrs_front.sv -----
// Input side: accepts requests, drops unknown kinds, queues the rest.
// Depends on mrs_pkg.
module mrs_front import mrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       in_item_i,
  output queue_t      head_o,
  input  logic        pop_i
);

  localparam int Depth = 2;

  item_t       fifo_q [Depth];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, take, known;

  assign in_ready_o = (cnt_q != 2'(Depth));
  assign known      = (in_item_i.kind == KIND_BYTE) || (in_item_i.kind == KIND_WRITE) ||
                      (in_item_i.kind == KIND_READ);
  assign push       = in_valid_i && in_ready_o && known;
  assign take       = pop_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = fifo_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = take ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= in_item_i;
    end
  end

endmodule

// ----- hdl/mrs_engine.sv -----
// Back end: frame buffer, frame check, holding registers and response streaming.
// Depends on mrs_pkg.
module mrs_engine import mrs_pkg::*; #(
  parameter int NUM_REGS    = 16,
  parameter int FRAME_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  slave_addr_i,
  input  logic [7:0]  prot_idx_i,
  input  queue_t      head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [15:0] out_value_o
);

  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int CW  = $clog2(FRAME_BYTES + 1);
  localparam int IW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int NW  = $clog2(NUM_REGS + 1);
  localparam int RLW = 7;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_RDHI  = 6'b000100,
    ST_RDLO  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [7:0]       mem [FRAME_BYTES];
  logic [7:0]       rdata_q;
  logic             mem_we;
  logic [CW-1:0]    count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [15:0]      rxcrc_q, rxcrc_d;
  logic [7:0]       hdr_q [HDR_BYTES];
  logic [7:0]       hdr_d [HDR_BYTES];
  logic [15:0]      hold_q [NUM_REGS];
  logic             hw_en;
  logic [IW-1:0]    hw_idx;
  logic [15:0]      hw_data;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [7:0]       hi_q, hi_d;
  logic [IW-1:0]    widx_q, widx_d;
  logic [NW-1:0]    rem_q, rem_d;
  resp_e            rtype_q, rtype_d;
  logic [RLW-1:0]   k_q, k_d, rlen_q, rlen_d;
  logic [7:0]       code_q, code_d, nbytes_q, nbytes_d;
  logic [15:0]      txcrc_q, txcrc_d;
  logic [IW-1:0]    cur_q, cur_d;
  logic             half_q, half_d;
  logic             ovalid_q, ovalid_d, okind_q, okind_d, olast_q, olast_d;
  logic [7:0]       obyte_q, obyte_d;
  logic [15:0]      oval_q, oval_d;
  logic             out_free;
  logic [IW-1:0]    rd_idx;
  logic [15:0]      hsel;
  logic [15:0]      fa, fn;
  logic [9:0]       len10;
  logic             drop, range_bad, idx_ok;
  logic [7:0]       gen;

  assign out_free = !ovalid_q || out_ready_i;
  assign rd_idx   = (state_q == ST_EMIT) ? cur_q : head_i.item.local_index[IW-1:0];
  assign hsel     = ({{(32-IW){1'b0}}, rd_idx} < 32'(NUM_REGS)) ? hold_q[rd_idx] : 16'h0;
  assign fa       = {hdr_q[2], hdr_q[3]};
  assign fn       = {hdr_q[4], hdr_q[5]};
  assign len10    = 10'(count_q);
  assign drop     = ovf_q || (len10 < 10'd4) ||
                    ((hdr_q[0] != slave_addr_i) && (hdr_q[0] != 8'h00)) || (rxcrc_q != 16'h0);
  assign range_bad = (17'(fa) + 17'(fn)) > 17'(NUM_REGS);
  assign idx_ok   = head_i.item.local_index < 8'(NUM_REGS);

  // next response byte
  always_comb begin
    gen = 8'h00;
    if (k_q == rlen_q - RLW'(2)) begin
      gen = txcrc_q[7:0];
    end else if (k_q == rlen_q - RLW'(1)) begin
      gen = txcrc_q[15:8];
    end else if (k_q == '0) begin
      gen = slave_addr_i;
    end else begin
      unique case (rtype_q)
        RESP_EXC:  gen = (k_q == RLW'(1)) ? (hdr_q[1] | EXC_FLAG) : code_q;
        RESP_READ: begin
          if (k_q == RLW'(1))      gen = FC_READ;
          else if (k_q == RLW'(2)) gen = nbytes_q;
          else                     gen = half_q ? hsel[7:0] : hsel[15:8];
        end
        RESP_ECHO: gen = hdr_q[k_q[2:0]];
        default:   gen = 8'h00;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    rxcrc_d  = rxcrc_q;
    hdr_d    = hdr_q;
    ptr_d    = ptr_q;
    hi_d     = hi_q;
    widx_d   = widx_q;
    rem_d    = rem_q;
    rtype_d  = rtype_q;
    k_d      = k_q;
    rlen_d   = rlen_q;
    code_d   = code_q;
    nbytes_d = nbytes_q;
    txcrc_d  = txcrc_q;
    cur_d    = cur_q;
    half_d   = half_q;
    ovalid_d = ovalid_q && !out_ready_i;
    okind_d  = okind_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    oval_d   = oval_q;
    mem_we   = 1'b0;
    hw_en    = 1'b0;
    hw_idx   = '0;
    hw_data  = 16'h0;
    pop_o    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid && out_free) begin
          pop_o = 1'b1;
          unique case (head_i.item.kind)
            KIND_BYTE: begin
              if (count_q < CW'(FRAME_BYTES)) begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
                rxcrc_d = crc16_update(rxcrc_q, head_i.item.rx_byte);
                if (count_q < CW'(HDR_BYTES)) begin
                  hdr_d[count_q[2:0]] = head_i.item.rx_byte;
                end
              end else begin
                ovf_d = 1'b1;
              end
              if (head_i.item.frame_end) state_d = ST_CHECK;
            end
            KIND_WRITE: begin
              hw_en   = idx_ok;
              hw_idx  = head_i.item.local_index[IW-1:0];
              hw_data = head_i.item.local_value;
            end
            KIND_READ: begin
              ovalid_d = 1'b1;
              okind_d  = OUT_LOCAL;
              obyte_d  = 8'h00;
              olast_d  = 1'b1;
              oval_d   = idx_ok ? hsel : 16'h0;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        count_d = '0;
        ovf_d   = 1'b0;
        rxcrc_d = CRC_SEED;
        k_d     = '0;
        txcrc_d = CRC_SEED;
        half_d  = 1'b0;
        state_d = ST_IDLE;
        rtype_d = RESP_EXC;
        rlen_d  = RLW'(5);
        if (!drop) begin
          priority if (hdr_q[1] == FC_READ) begin
            if (len10 >= 10'd8) begin
              state_d = ST_EMIT;
              if (range_bad) begin
                code_d = EXC_RANGE;
              end else begin
                rtype_d  = RESP_READ;
                rlen_d   = RLW'(5) + RLW'({fn[5:0], 1'b0});
                nbytes_d = {fn[6:0], 1'b0};
                cur_d    = fa[IW-1:0];
              end
            end
          end else if (hdr_q[1] == FC_WRITE1) begin
            if (len10 >= 10'd8) begin
              state_d = ST_EMIT;
              if ((fa >= 16'(NUM_REGS)) || (fa == {8'h00, prot_idx_i})) begin
                code_d = EXC_RANGE;
              end else begin
                hw_en   = 1'b1;
                hw_idx  = fa[IW-1:0];
                hw_data = fn;
                rtype_d = RESP_ECHO;
                rlen_d  = RLW'(8);
              end
            end
          end else if (hdr_q[1] == FC_WRITEN) begin
            if (len10 >= 10'd9) begin
              state_d = ST_EMIT;
              if ((len10 < (10'(hdr_q[6]) + 10'd9)) || ({fn, 1'b0} != 17'(hdr_q[6]))) begin
                code_d = EXC_COUNT;
              end else if (range_bad) begin
                code_d = EXC_RANGE;
              end else begin
                rtype_d = RESP_ECHO;
                rlen_d  = RLW'(8);
                ptr_d   = AW'(HDR_BYTES);
                widx_d  = fa[IW-1:0];
                rem_d   = fn[NW-1:0];
                if (fn != 16'h0) state_d = ST_RDHI;
              end
            end
          end else begin
            state_d = ST_EMIT;
            code_d  = EXC_FUNC;
          end
        end
      end
      ST_RDHI: begin
        ptr_d   = ptr_q + AW'(1);
        state_d = ST_RDLO;
      end
      ST_RDLO: begin
        hi_d    = rdata_q;
        ptr_d   = ptr_q + AW'(1);
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        hw_en   = 1'b1;
        hw_idx  = widx_q;
        hw_data = {hi_q, rdata_q};
        widx_d  = widx_q + IW'(1);
        rem_d   = rem_q - NW'(1);
        state_d = (rem_q == NW'(1)) ? ST_EMIT : ST_RDHI;
      end
      ST_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = OUT_FRAME;
          obyte_d  = gen;
          olast_d  = (k_q == rlen_q - RLW'(1));
          oval_d   = 16'h0;
          k_d      = k_q + RLW'(1);
          if (k_q < rlen_q - RLW'(2)) begin
            txcrc_d = crc16_update(txcrc_q, gen);
            if ((rtype_q == RESP_READ) && (k_q >= RLW'(3))) begin
              half_d = ~half_q;
              if (half_q) cur_d = cur_q + IW'(1);
            end
          end
          if (k_q == rlen_q - RLW'(1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      rxcrc_q  <= CRC_SEED;
      ovalid_q <= 1'b0;
      rem_q    <= '0;
      k_q      <= '0;
      rlen_q   <= RLW'(5);
      for (int i = 0; i < NUM_REGS; i++) hold_q[i] <= 16'h0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      rxcrc_q  <= rxcrc_d;
      ovalid_q <= ovalid_d;
      rem_q    <= rem_d;
      k_q      <= k_d;
      rlen_q   <= rlen_d;
      if (hw_en) hold_q[hw_idx] <= hw_data;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q    <= hdr_d;
    ptr_q    <= ptr_d;
    hi_q     <= hi_d;
    widx_q   <= widx_d;
    rtype_q  <= rtype_d;
    code_q   <= code_d;
    nbytes_q <= nbytes_d;
    txcrc_q  <= txcrc_d;
    cur_q    <= cur_d;
    half_q   <= half_d;
    okind_q  <= okind_d;
    obyte_q  <= obyte_d;
    olast_q  <= olast_d;
    oval_q   <= oval_d;
  end

  // frame buffer, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[count_q[AW-1:0]] <= head_i.item.rx_byte;
    rdata_q <= mem[ptr_q];
  end

  assign out_valid_o = ovalid_q;
  assign out_kind_o  = okind_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;
  assign out_value_o = oval_q;

endmodule
